// File: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int REGION_SIZE = 4096;
  localparam int HEADER_SIZE = 8;
  localparam int ADDR_W      = $clog2(REGION_SIZE);
  localparam int OFF_W       = 13;
  localparam int SIZE_W      = 14;
  localparam int POS_W       = 14;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_BLOCK = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam hdr_t HDR_RESET = '{used: 1'b0, size: SIZE_W'(REGION_SIZE - HEADER_SIZE)};

  typedef struct packed {
    logic             mode;
    logic [OFF_W-1:0] req_size;
    logic [OFF_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] payload_offset;
  } out_item_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    hdr_t              wdata;
  } mem_req_t;

endpackage

// File: src/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: single-port synchronous RAM with registered read data.
// Entry 0 reads as the initial free block until first written.
// ----------------------------------------------------------------------------
module ffha_hdr_mem
  import ffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output hdr_t     rdata
);

  hdr_t mem [REGION_SIZE];
  hdr_t q_r;
  logic hdr0_ok_r;
  logic use_rst_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      q_r <= mem[req.addr];
    end
  end

  // entry 0 is the only one read before it is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_ok_r <= 1'b0;
      use_rst_r <= 1'b0;
    end else begin
      if (req.wr && req.addr == '0) begin
        hdr0_ok_r <= 1'b1;
      end
      if (req.rd) begin
        use_rst_r <= (req.addr == '0) && !hdr0_ok_r;
      end
    end
  end

  assign rdata = use_rst_r ? HDR_RESET : q_r;

endmodule

// File: src/ffha_engine.sv
// ----------------------------------------------------------------------------
// ffha_engine
// Sequencer: walks the header chain through the header store and does the
// read-modify-write for allocate, split, free and merge.
// ----------------------------------------------------------------------------
module ffha_engine
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  item,
  output logic      ready,
  output mem_req_t  mem_req,
  input  hdr_t      mem_rdata,
  output logic      done,
  output out_item_t result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_F_NRD,
    S_F_NCHK,
    S_F_WR,
    S_F_PWR
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  cur_r, cur_nxt;
  logic [OFF_W-1:0]  req_r, req_nxt;
  logic [OFF_W-1:0]  p_r, p_nxt;
  logic [ADDR_W-1:0] prev_r, prev_nxt;
  logic              has_prev_r, has_prev_nxt;
  hdr_t              prev_hdr_r, prev_hdr_nxt;
  logic [SIZE_W-1:0] psize_r, psize_nxt;
  logic [POS_W-1:0]  nx_r, nx_nxt;
  logic [ADDR_W-1:0] sp_addr_r, sp_addr_nxt;
  logic [SIZE_W-1:0] sp_size_r, sp_size_nxt;

  logic [POS_W-1:0]  next_pos;
  logic [POS_W-1:0]  split_pos;
  logic              cur_end;

  assign next_pos  = cur_r + POS_W'(HEADER_SIZE) + POS_W'(mem_rdata.size);
  assign split_pos = cur_r + POS_W'(HEADER_SIZE) + POS_W'(req_r);
  assign cur_end   = cur_r >= POS_W'(REGION_SIZE);
  assign ready     = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    req_nxt      = req_r;
    p_nxt        = p_r;
    prev_nxt     = prev_r;
    has_prev_nxt = has_prev_r;
    prev_hdr_nxt = prev_hdr_r;
    psize_nxt    = psize_r;
    nx_nxt       = nx_r;
    sp_addr_nxt  = sp_addr_r;
    sp_size_nxt  = sp_size_r;
    mem_req      = '0;
    done         = 1'b0;
    result       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_nxt      = '0;
          has_prev_nxt = 1'b0;
          req_nxt      = item.req_size;
          p_nxt        = item.free_offset - OFF_W'(HEADER_SIZE);
          if (item.mode == MODE_ALLOC) begin
            state_nxt = S_A_RD;
          end else if (item.free_offset == '0 ||
                       item.free_offset >= OFF_W'(REGION_SIZE)) begin
            done          = 1'b1;
            result.status = ST_RANGE;
          end else if (item.free_offset < OFF_W'(HEADER_SIZE)) begin
            done          = 1'b1;
            result.status = ST_NOT_BLOCK;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end

      S_A_RD: begin
        if (cur_end) begin
          done          = 1'b1;
          result.status = ST_NO_SPACE;
          state_nxt     = S_IDLE;
        end else begin
          mem_req.rd   = 1'b1;
          mem_req.addr = cur_r[ADDR_W-1:0];
          state_nxt    = S_A_CHK;
        end
      end

      S_A_CHK: begin
        mem_req.addr = cur_r[ADDR_W-1:0];
        if (!mem_rdata.used &&
            mem_rdata.size >= SIZE_W'(req_r) + SIZE_W'(HEADER_SIZE + 1)) begin
          mem_req.wr    = 1'b1;
          mem_req.wdata = '{used: 1'b1, size: SIZE_W'(req_r)};
          sp_addr_nxt   = split_pos[ADDR_W-1:0];
          sp_size_nxt   = mem_rdata.size - SIZE_W'(req_r) - SIZE_W'(HEADER_SIZE);
          state_nxt     = S_A_SPLIT;
        end else if (!mem_rdata.used && mem_rdata.size >= SIZE_W'(req_r)) begin
          mem_req.wr            = 1'b1;
          mem_req.wdata         = '{used: 1'b1, size: mem_rdata.size};
          done                  = 1'b1;
          result.status         = ST_OK;
          result.payload_offset = OFF_W'(cur_r + POS_W'(HEADER_SIZE));
          state_nxt             = S_IDLE;
        end else begin
          cur_nxt   = next_pos;
          state_nxt = S_A_RD;
        end
      end

      S_A_SPLIT: begin
        mem_req.wr            = 1'b1;
        mem_req.addr          = sp_addr_r;
        mem_req.wdata         = '{used: 1'b0, size: sp_size_r};
        done                  = 1'b1;
        result.status         = ST_OK;
        result.payload_offset = OFF_W'(cur_r + POS_W'(HEADER_SIZE));
        state_nxt             = S_IDLE;
      end

      S_F_RD: begin
        if (cur_end || cur_r > POS_W'(p_r)) begin
          done          = 1'b1;
          result.status = ST_NOT_BLOCK;
          state_nxt     = S_IDLE;
        end else begin
          mem_req.rd   = 1'b1;
          mem_req.addr = cur_r[ADDR_W-1:0];
          state_nxt    = S_F_CHK;
        end
      end

      S_F_CHK: begin
        if (cur_r == POS_W'(p_r)) begin
          if (mem_rdata.used) begin
            psize_nxt = mem_rdata.size;
            nx_nxt    = next_pos;
            state_nxt = S_F_NRD;
          end else begin
            done          = 1'b1;
            result.status = ST_NOT_BLOCK;
            state_nxt     = S_IDLE;
          end
        end else begin
          prev_nxt     = cur_r[ADDR_W-1:0];
          prev_hdr_nxt = mem_rdata;
          has_prev_nxt = 1'b1;
          cur_nxt      = next_pos;
          state_nxt    = S_F_RD;
        end
      end

      S_F_NRD: begin
        if (nx_r < POS_W'(REGION_SIZE)) begin
          mem_req.rd   = 1'b1;
          mem_req.addr = nx_r[ADDR_W-1:0];
          state_nxt    = S_F_NCHK;
        end else begin
          state_nxt = S_F_WR;
        end
      end

      S_F_NCHK: begin
        if (!mem_rdata.used) begin
          psize_nxt = psize_r + SIZE_W'(HEADER_SIZE) + mem_rdata.size;
        end
        state_nxt = S_F_WR;
      end

      S_F_WR: begin
        mem_req.wr    = 1'b1;
        mem_req.addr  = p_r[ADDR_W-1:0];
        mem_req.wdata = '{used: 1'b0, size: psize_r};
        if (has_prev_r && !prev_hdr_r.used) begin
          state_nxt = S_F_PWR;
        end else begin
          done          = 1'b1;
          result.status = ST_OK;
          state_nxt     = S_IDLE;
        end
      end

      S_F_PWR: begin
        mem_req.wr    = 1'b1;
        mem_req.addr  = prev_r;
        mem_req.wdata = '{used: 1'b0,
                          size: prev_hdr_r.size + SIZE_W'(HEADER_SIZE) + psize_r};
        done          = 1'b1;
        result.status = ST_OK;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cur_r      <= cur_nxt;
    req_r      <= req_nxt;
    p_r        <= p_nxt;
    prev_r     <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    prev_hdr_r <= prev_hdr_nxt;
    psize_r    <= psize_nxt;
    nx_r       <= nx_nxt;
    sp_addr_r  <= sp_addr_nxt;
    sp_size_r  <= sp_size_nxt;
  end

endmodule

// File: src/first_fit_heap_allocator_top.sv
// Sequence: allocate reads and checks each block header in turn, then splits
// the chosen block or ends with a no-space check at the chain's end; free
// reads each header up to the target and the one after it, then writes the
// merged free block; range errors finish in the accept cycle. The result
// word follows in the next cycle; the single header-store port sets rate.
// Reset: synchronous, active low; heap returns to one free block, no pass.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over an implicit block list kept in a header RAM.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mem_req_t  mem_req;
  hdr_t      mem_rdata;
  logic      eng_ready;
  logic      eng_done;
  out_item_t eng_result;
  logic      start;
  logic      out_valid_r;
  out_item_t out_data_r;

  // output word must be free before a new request starts
  assign in_stall = !eng_ready || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;

  ffha_hdr_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ffha_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .ready     (eng_ready),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .done      (eng_done),
    .result    (eng_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (eng_done) begin
      out_data_r <= eng_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
